// ----- rtl/b64c_pkg.sv -----
// Shared types, codes and character tables for the Base64 codec.
// No dependencies; imported by every module of the codec.
package b64c_pkg;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_LEN_ERR = 2'd1;
	localparam logic [1:0] ST_BAD_CHR = 2'd2;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      cnt;
		logic            last;
		logic [1:0]      status;
	} rec_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] sx;
	} sextet_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'd65 + w;
		end else if (v < 6'd52) begin
			return 8'd71 + w;
		end else if (v < 6'd62) begin
			return w - 8'd4;
		end else if (v == 6'd62) begin
			return PLUS_CHAR;
		end
		return SLASH_CHAR;
	endfunction

	function automatic sextet_t char_to_sextet(input logic [7:0] c);
		sextet_t r;
		r.ok = 1'b1;
		r.sx = 6'd0;
		if (c >= 8'd65 && c <= 8'd90) begin
			r.sx = 6'(c - 8'd65);
		end else if (c >= 8'd97 && c <= 8'd122) begin
			r.sx = 6'(c - 8'd71);
		end else if (c >= 8'd48 && c <= 8'd57) begin
			r.sx = 6'(c + 8'd4);
		end else if (c == PLUS_CHAR) begin
			r.sx = 6'd62;
		end else if (c == SLASH_CHAR) begin
			r.sx = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- rtl/base64_codec_unit.sv -----
// Top level of the Base64 codec: APB mode register, group collector and
// output serializer. Depends on b64c_pkg, b64c_collect and b64c_serial.
//
// The codec sends one result beat per cycle while out_ready is high. Encoding
// takes three bytes and sends four characters, so its input is held off at
// times; decoding takes four characters and sends up to three bytes, so it
// accepts one character per cycle while the output is not held off. The
// output serializer, which drains one group record of up to four beats, sets
// the rate; one further finished group waits in the collector while earlier
// beats go out; a group's first beat passes the collector's record register
// and then the serializer's. A mode register write clears any partial group.
module base64_codec_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_out,
	output logic [1:0]  status
);
	import b64c_pkg::*;

	logic mode_q;
	logic mode_wr;
	logic rec_valid;
	logic take;
	rec_t rec;

	assign pready  = 1'b1;
	assign mode_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
	assign prdata  = (paddr[2] == 1'b0) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
		end else if (mode_wr) begin
			mode_q <= pwdata[0];
		end
	end

	b64c_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.clr       (mode_wr),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.last_in   (last_in),
		.take      (take),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	b64c_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (mode_wr),
		.rec_valid (rec_valid),
		.rec       (rec),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_out  (last_out),
		.status    (status)
	);

endmodule

// ----- rtl/b64c_collect.sv -----
// Group collector of the Base64 codec: gathers bytes or characters into a group
// and hands each finished group on as one record of up to four result beats.
// Depends on b64c_pkg.
module b64c_collect (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mode,
	input  logic           clr,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           last_in,
	input  logic           take,
	output logic           rec_valid,
	output b64c_pkg::rec_t rec
);
	import b64c_pkg::*;

	logic [23:0] bits_q, bits_d, enc_bits, dec_bits;
	logic [1:0]  fill_q, fill_d, fill_inc, drops;
	logic        pad_q, pad_d, bad_q, bad_d, bad_n;
	logic        done, accept, is_pad, rec_valid_s1;
	logic [5:0]  sx;
	sextet_t     cs;
	rec_t        rec_d, rec_s1;

	assign accept    = in_valid & in_ready;
	assign in_ready  = ~rec_valid_s1 | take;
	assign rec_valid = rec_valid_s1;
	assign rec       = rec_s1;
	assign fill_inc  = fill_q + 2'd1;
	assign cs        = char_to_sextet(in_byte);
	assign is_pad    = (in_byte == PAD_CHAR);
	assign sx        = is_pad ? 6'd0 : cs.sx;
	assign bad_n     = bad_q | (~cs.ok & ~is_pad);

	always_comb begin
		enc_bits = bits_q;
		unique case (fill_q)
			2'd0: enc_bits[23:16] = in_byte;
			2'd1: enc_bits[15:8]  = in_byte;
			default: enc_bits[7:0] = in_byte;
		endcase
		dec_bits = bits_q;
		unique case (fill_q)
			2'd0: dec_bits[23:18] = sx;
			2'd1: dec_bits[17:12] = sx;
			2'd2: dec_bits[11:6]  = sx;
			default: dec_bits[5:0] = sx;
		endcase
	end

	always_comb begin
		bits_d = bits_q;
		fill_d = fill_q;
		pad_d  = pad_q;
		bad_d  = bad_q;
		rec_d  = '0;
		done   = 1'b0;
		drops  = 2'd0;
		if (mode == MODE_ENC) begin
			rec_d.data[0] = sextet_to_char(enc_bits[23:18]);
			rec_d.data[1] = sextet_to_char(enc_bits[17:12]);
			rec_d.data[2] = (fill_inc == 2'd1) ? PAD_CHAR : sextet_to_char(enc_bits[11:6]);
			rec_d.data[3] = (fill_inc == 2'd3) ? sextet_to_char(enc_bits[5:0]) : PAD_CHAR;
			rec_d.cnt     = 2'd3;
			rec_d.last    = last_in;
			rec_d.status  = ST_OK;
			done          = (fill_inc == 2'd3) | last_in;
			if (done) begin
				bits_d = '0;
				fill_d = 2'd0;
				pad_d  = 1'b0;
				bad_d  = 1'b0;
			end else begin
				bits_d = enc_bits;
				fill_d = fill_inc;
			end
		end else if (fill_q != 2'd3) begin
			if (last_in) begin
				done         = 1'b1;
				rec_d.last   = 1'b1;
				rec_d.status = ST_LEN_ERR;
				bits_d       = '0;
				fill_d       = 2'd0;
				pad_d        = 1'b0;
				bad_d        = 1'b0;
			end else begin
				bits_d = dec_bits;
				fill_d = fill_inc;
				bad_d  = bad_n;
				if (fill_q == 2'd2) begin
					pad_d = is_pad;
				end
			end
		end else begin
			if (last_in) begin
				drops = {1'b0, pad_q} + {1'b0, is_pad};
			end
			done          = 1'b1;
			rec_d.data[0] = dec_bits[23:16];
			rec_d.data[1] = dec_bits[15:8];
			rec_d.data[2] = dec_bits[7:0];
			rec_d.data[3] = 8'd0;
			rec_d.cnt     = 2'd2 - drops;
			rec_d.last    = last_in;
			rec_d.status  = bad_n ? ST_BAD_CHR : ST_OK;
			bits_d        = '0;
			fill_d        = 2'd0;
			pad_d         = 1'b0;
			bad_d         = last_in ? 1'b0 : bad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q       <= '0;
			fill_q       <= 2'd0;
			pad_q        <= 1'b0;
			bad_q        <= 1'b0;
			rec_valid_s1 <= 1'b0;
		end else if (clr) begin
			bits_q       <= '0;
			fill_q       <= 2'd0;
			pad_q        <= 1'b0;
			bad_q        <= 1'b0;
			rec_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				bits_q <= bits_d;
				fill_q <= fill_d;
				pad_q  <= pad_d;
				bad_q  <= bad_d;
			end
			if (accept && done) begin
				rec_valid_s1 <= 1'b1;
			end else if (take) begin
				rec_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && done) begin
			rec_s1 <= rec_d;
		end
	end

	a_enc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(mode == MODE_ENC) |-> (fill_q != 2'd3))
		else $error("encode group holds more than two bytes");
	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> (fill_q == 2'd3))
		else $error("pad flag set outside the fourth position");
	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid_s1 && !take && !clr) |=> rec_valid_s1)
		else $error("pending group record lost");

endmodule

// ----- rtl/b64c_serial.sv -----
// Output serializer of the Base64 codec: holds one group record and sends
// its result beats one per cycle while out_ready is high. Depends on b64c_pkg.
module b64c_serial (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr,
	input  logic           rec_valid,
	input  b64c_pkg::rec_t rec,
	output logic           take,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           last_out,
	output logic [1:0]     status
);
	import b64c_pkg::*;

	logic       valid_q;
	logic [1:0] idx_q;
	logic       final_beat;
	rec_t       rec_q;

	assign final_beat = (idx_q == rec_q.cnt);
	assign take       = rec_valid & (~valid_q | (out_ready & final_beat));
	assign out_valid  = valid_q;
	assign out_byte   = rec_q.data[idx_q];
	assign last_out   = rec_q.last & final_beat;
	assign status     = rec_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (clr) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (valid_q && out_ready) begin
			valid_q <= ~final_beat;
			idx_q   <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rec_q <= rec;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= rec_q.cnt))
		else $error("beat index beyond record length");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !clr) |=> (valid_q && idx_q == 2'd0))
		else $error("new record does not start at its first beat");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for base64_codec_unit: encodes and decodes random and
// directed streams through valid/ready channels and checks every output beat.
// Depends on b64c_pkg and the base64_codec_unit RTL.
`timescale 1ns / 100ps

module tb_top;
	import b64c_pkg::*;

	localparam logic [2:0] ADDR_MODE = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] status;
	} out_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        last_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last_out;
	logic [1:0]  status;

	in_beat_t    pending_beats[$];
	out_beat_t   expected_beats[$];
	in_beat_t    next_beat;
	out_beat_t   want;
	int          beats_queued = 0;
	int          beats_taken = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          in_gap = 0;
	int          out_stall = 0;
	bit          steady = 1'b0;

	logic        cur_mode = MODE_ENC;
	logic [23:0] grp_bits = '0;
	int unsigned grp_fill = 0;
	logic        third_pad = 1'b0;
	logic        saw_bad = 1'b0;

	base64_codec_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_out(last_out),
		.status(status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] b64_char(logic [5:0] v);
		if (v < 6'd26) return 8'h41 + 8'(v);
		if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
		if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
		if (v == 6'd62) return PLUS_CHAR;
		return SLASH_CHAR;
	endfunction

	// Returns {valid, sextet}; valid is low for any character outside the alphabet.
	function automatic logic [6:0] b64_value(logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return {1'b1, 6'(c - 8'h41)};
		if (c >= 8'h61 && c <= 8'h7A) return {1'b1, 6'(c - 8'h61 + 8'd26)};
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
		if (c == PLUS_CHAR) return {1'b1, 6'd62};
		if (c == SLASH_CHAR) return {1'b1, 6'd63};
		return 7'd0;
	endfunction

	function automatic void clear_group();
		grp_bits = '0;
		grp_fill = 0;
		third_pad = 1'b0;
		saw_bad = 1'b0;
	endfunction

	function automatic void expect_beat(logic [7:0] d, logic l, logic [1:0] s);
		out_beat_t b;
		b.data = d;
		b.last = l;
		b.status = s;
		expected_beats.push_back(b);
	endfunction

	function automatic void predict_encode(logic [7:0] d, logic l);
		int unsigned n;
		grp_bits = grp_bits | (24'(d) << (16 - 8 * grp_fill));
		n = grp_fill + 1;
		if (n < 3 && !l) begin
			grp_fill = n;
		end else begin
			for (int i = 0; i < 4; i++) begin
				expect_beat((i < n + 1) ? b64_char(6'(grp_bits >> (18 - 6 * i))) : PAD_CHAR,
					l && i == 3, ST_OK);
			end
			clear_group();
		end
	endfunction

	function automatic void predict_decode(logic [7:0] c, logic l);
		logic [6:0]  look;
		logic        is_pad;
		logic [1:0]  st;
		int unsigned n_bytes;
		is_pad = (c == PAD_CHAR);
		look = b64_value(c);
		if (!is_pad && !look[6]) saw_bad = 1'b1;
		if (!is_pad) grp_bits = grp_bits | (24'(look[5:0]) << (18 - 6 * grp_fill));
		if (grp_fill < 3) begin
			if (grp_fill == 2) third_pad = is_pad;
			if (l) begin
				expect_beat(8'h00, 1'b1, ST_LEN_ERR);
				clear_group();
			end else begin
				grp_fill = grp_fill + 1;
			end
		end else begin
			st = saw_bad ? ST_BAD_CHR : ST_OK;
			n_bytes = 3 - (l ? (int'(third_pad) + int'(is_pad)) : 0);
			for (int i = 0; i < n_bytes; i++) begin
				expect_beat(8'(grp_bits >> (16 - 8 * i)), l && i + 1 == n_bytes, st);
			end
			if (l) begin
				clear_group();
			end else begin
				grp_bits = '0;
				grp_fill = 0;
				third_pad = 1'b0;
			end
		end
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic void queue_beat(logic [7:0] d, logic l);
		in_beat_t b;
		b.data = d;
		b.last = l;
		pending_beats.push_back(b);
		beats_queued++;
	endfunction

	function automatic void queue_text(string s, bit end_stream);
		for (int i = 0; i < s.len(); i++) queue_beat(s[i], end_stream && i == s.len() - 1);
	endfunction

	function automatic int queue_encode_stream();
		int unsigned len;
		bit          open;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
		open = ($urandom_range(0, 19) == 0);
		for (int i = 0; i < len; i++) queue_beat(8'($urandom_range(0, 255)), !open && i == len - 1);
		return len;
	endfunction

	function automatic int queue_decode_stream();
		logic [7:0]  txt[$];
		int unsigned groups;
		int unsigned kind;
		int unsigned pads;
		int unsigned cut;
		groups = $urandom_range(1, 4);
		kind = $urandom_range(0, 99);
		pads = $urandom_range(0, 2);
		for (int i = 0; i < 4 * groups; i++) txt.push_back(b64_char(6'($urandom_range(0, 63))));
		if (pads > 0) txt[txt.size() - 1] = PAD_CHAR;
		if (pads > 1) txt[txt.size() - 2] = PAD_CHAR;
		if (kind >= 70 && kind < 85) begin
			foreach (txt[i]) begin
				if ($urandom_range(0, 5) == 0) begin
					txt[i] = ($urandom_range(0, 3) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
				end
			end
		end else if (kind >= 85 && kind < 95) begin
			cut = $urandom_range(1, 3);
			repeat (cut) begin
				if (txt.size() > 1) void'(txt.pop_back());
			end
		end
		foreach (txt[i]) queue_beat(txt[i], kind < 95 && i == txt.size() - 1);
		return txt.size();
	endfunction

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_MODE) begin
			cur_mode = data[0];
			clear_group();
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_mode();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_MODE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, cur_mode}) begin
			mismatches++;
			$display("%0t ns: mode readback expected %h, got %h", $time, {31'b0, cur_mode}, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_mode(input logic m);
		write_reg(ADDR_MODE, {31'b0, m});
		check_mode();
	endtask

	task automatic drain();
		while (beats_taken != beats_queued || expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (cur_mode == MODE_ENC) predict_encode(in_byte, last_in);
				else predict_decode(in_byte, last_in);
				beats_taken++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					next_beat = pending_beats.pop_front();
					in_valid <= 1'b1;
					in_byte <= next_beat.data;
					last_in <= next_beat.last;
					in_gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 40) begin
						$display("%0t ns: unexpected beat: expected none, got byte %h last %b status %0d",
							$time, out_byte, last_out, status);
					end
				end else begin
					want = expected_beats.pop_front();
					if (out_byte !== want.data || last_out !== want.last || status !== want.status) begin
						mismatches++;
						if (mismatches <= 40) begin
							$display("%0t ns: beat mismatch: expected byte %h last %b status %0d, %s",
								$time, want.data, want.last, want.status, "got:");
							$display("    byte %h last %b status %0d", out_byte, last_out, status);
						end
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0) out_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("** base64_codec_unit: FAILED **");
		$finish;
	end

	initial begin
		int queued;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(MODE_ENC);
		queue_beat(8'hFB, 1'b0);
		queue_beat(8'hFF, 1'b0);
		queue_beat(8'hBF, 1'b0);
		queue_beat(8'hFF, 1'b1);
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h00, 1'b1);
		queue_beat(8'h5A, 1'b0);
		drain();
		// A write to an unmapped address must leave the mode alone.
		write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
		check_mode();

		// The open encode group above is dropped by this mode write.
		set_mode(MODE_DEC);
		queue_text("+/+/", 1'b1);
		queue_text("TW=A", 1'b1);
		queue_text("=z*9", 1'b0);
		queue_text("0a==", 1'b1);
		queue_text("#", 1'b1);
		queue_text("Tw", 1'b0);
		drain();

		for (int p = 0; p < 6; p++) begin
			set_mode((p % 2 == 0) ? MODE_ENC : MODE_DEC);
			steady = (p == 2 || p == 3);
			queued = 0;
			while (queued < 60) begin
				if (cur_mode == MODE_ENC) queued += queue_encode_stream();
				else queued += queue_decode_stream();
			end
			drain();
		end

		if (expected_beats.size() != 0) begin
			mismatches++;
			$display("%0t ns: %0d expected beats never arrived", $time, expected_beats.size());
		end
		if (mismatches == 0) begin
			$display("** base64_codec_unit: PASSED **");
		end else begin
			$display("** base64_codec_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ----- base64_codec_unit.f -----
rtl/b64c_pkg.sv
rtl/b64c_collect.sv
rtl/b64c_serial.sv
rtl/base64_codec_unit.sv
test/tb_top.sv
